@@ hw/rtl/sellspmv_pkg.sv @@
// Shared types, codes and arithmetic helpers for the sliced-ELL SpMV core.
`timescale 1ns / 1ps
package sellspmv_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_VEC = 2'd0,
        OP_LOAD_OLD = 2'd1,
        OP_HEADER   = 2'd2,
        OP_ENTRY    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_DRAIN,
        EM_READ,
        EM_WRITE
    } emit_state_t;

    // Per-item control from the chunk scheduler
    typedef struct packed {
        logic       entry;   // a matrix entry goes into the MAC pipeline
        logic [1:0] lane;    // lane of that entry
        logic       kill;    // header: drop in-flight entries, clear sums
        logic       start;   // chunk complete: emit its four rows
        logic [7:0] chunk;   // chunk number for the emit
    } sched_ctl_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Remainder of a 10-bit value by an elaboration-time constant:
    // restoring compare-subtract, only the steps that can fire are kept.
    function automatic logic [9:0] mod_const(input logic [9:0] value, input int depth);
        int r;
        r = int'(value);
        for (int k = 9; k >= 0; k--) begin
            if (((depth << k) <= 1023) && (r >= (depth << k)))
                r = r - (depth << k);
        end
        return r[9:0];
    endfunction

endpackage

@@ hw/rtl/sellspmv_sched.sv @@
// Chunk scheduler: header bookkeeping and lane decode of matrix entries.
`timescale 1ns / 1ps
module sellspmv_sched #(
    parameter int MAX_ROW_LENGTH = 255
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  sellspmv_pkg::op_t       op,
    input  logic [9:0]              index,
    input  logic [7:0]              chunk_min,
    input  logic [3:0][7:0]         row_len,
    output sellspmv_pkg::sched_ctl_t ctl
);
    import sellspmv_pkg::*;

    localparam int MaxLen = (MAX_ROW_LENGTH > 255) ? 255 : MAX_ROW_LENGTH;
    localparam logic [7:0] MaxLen8 = 8'(MaxLen);

    logic [3:0][7:0] len_reg, len_next;
    logic [7:0]      common_reg, common_next;
    logic [9:0]      total_reg, total_next;
    logic [9:0]      seen_reg, seen_next;
    logic [1:0]      rem_lane_reg, rem_lane_next;
    logic [7:0]      rem_pos_reg, rem_pos_next;
    logic [7:0]      chunk_reg, chunk_next;
    logic            open_reg, open_next;

    logic [3:0][7:0] hdr_len;
    logic [7:0]      hdr_min, hdr_short01, hdr_short23, hdr_shortest;
    logic [9:0]      hdr_total;

    always_comb begin
        for (int i = 0; i < 4; i++)
            hdr_len[i] = (row_len[i] > MaxLen8) ? MaxLen8 : row_len[i];
        hdr_min      = (chunk_min > MaxLen8) ? MaxLen8 : chunk_min;
        hdr_short01  = (hdr_len[1] < hdr_len[0]) ? hdr_len[1] : hdr_len[0];
        hdr_short23  = (hdr_len[3] < hdr_len[2]) ? hdr_len[3] : hdr_len[2];
        hdr_shortest = (hdr_short23 < hdr_short01) ? hdr_short23 : hdr_short01;
        hdr_total    = ({2'b00, hdr_len[0]} + {2'b00, hdr_len[1]})
                     + ({2'b00, hdr_len[2]} + {2'b00, hdr_len[3]});
    end

    always_comb begin
        logic [1:0] l;
        logic [7:0] p;
        len_next      = len_reg;
        common_next   = common_reg;
        total_next    = total_reg;
        seen_next     = seen_reg;
        rem_lane_next = rem_lane_reg;
        rem_pos_next  = rem_pos_reg;
        chunk_next    = chunk_reg;
        open_next     = open_reg;
        ctl           = '0;
        ctl.chunk     = chunk_reg;
        l             = rem_lane_reg;
        p             = rem_pos_reg;
        // skip past rows whose remainder is used up
        for (int i = 0; i < 3; i++) begin
            if ((l != 2'd3) && (p >= (len_reg[l] - common_reg))) begin
                l = l + 2'd1;
                p = '0;
            end
        end
        if (accept) begin
            unique case (op)
                OP_HEADER: begin
                    len_next      = hdr_len;
                    common_next   = (hdr_min > hdr_shortest) ? hdr_shortest : hdr_min;
                    total_next    = hdr_total;
                    seen_next     = '0;
                    rem_lane_next = '0;
                    rem_pos_next  = '0;
                    chunk_next    = index[7:0];
                    ctl.kill      = 1'b1;
                    ctl.chunk     = index[7:0];
                    if (hdr_total == '0) begin
                        ctl.start = 1'b1;
                        open_next = 1'b0;
                    end else begin
                        open_next = 1'b1;
                    end
                end
                OP_ENTRY: begin
                    if (open_reg) begin
                        ctl.entry = 1'b1;
                        if (seen_reg < {common_reg, 2'b00}) begin
                            ctl.lane = seen_reg[1:0];
                        end else begin
                            ctl.lane      = l;
                            rem_lane_next = l;
                            rem_pos_next  = p + 8'd1;
                        end
                        seen_next = seen_reg + 10'd1;
                        if (seen_next >= total_reg) begin
                            ctl.start = 1'b1;
                            open_next = 1'b0;
                        end
                    end
                end
                OP_LOAD_VEC, OP_LOAD_OLD: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            common_reg   <= '0;
            total_reg    <= '0;
            seen_reg     <= '0;
            rem_lane_reg <= '0;
            rem_pos_reg  <= '0;
            chunk_reg    <= '0;
            open_reg     <= 1'b0;
        end else begin
            len_reg      <= len_next;
            common_reg   <= common_next;
            total_reg    <= total_next;
            seen_reg     <= seen_next;
            rem_lane_reg <= rem_lane_next;
            rem_pos_reg  <= rem_pos_next;
            chunk_reg    <= chunk_next;
            open_reg     <= open_next;
        end
    end

endmodule

@@ hw/rtl/sellspmv_mac.sv @@
// Vector memory with gather read, multiplier and the four row accumulators.
`timescale 1ns / 1ps
module sellspmv_mac #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     vec_we,
    input  logic [9:0]               index,
    input  logic signed [31:0]       data,
    input  sellspmv_pkg::sched_ctl_t ctl,
    input  logic                     clear,
    output logic                     busy,
    output logic [3:0][63:0]         acc
);
    import sellspmv_pkg::*;

    localparam int VecAw = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    logic [31:0]        vec_mem [VECTOR_DEPTH];
    logic [VecAw-1:0]   vec_addr;
    logic signed [31:0] vec_rd_reg;

    logic               v1_reg, v1_next;
    logic [1:0]         lane1_reg;
    logic signed [31:0] val1_reg;
    logic               v2_reg, v2_next;
    logic [1:0]         lane2_reg;
    logic signed [63:0] prod_reg, prod_next;
    logic [3:0][63:0]   acc_reg, acc_next;

    assign vec_addr = VecAw'(mod_const(index, VECTOR_DEPTH));

    // gather: write for loads, registered read for entries
    always_ff @(posedge aclk) begin
        if (vec_we)
            vec_mem[vec_addr] <= data;
        if (ctl.entry)
            vec_rd_reg <= vec_mem[vec_addr];
    end

    always_comb begin
        prod_next = val1_reg * vec_rd_reg;
        v1_next   = ctl.entry;
        v2_next   = v1_reg;
        acc_next  = acc_reg;
        if (v2_reg)
            acc_next[lane2_reg] = sat_add64(acc_reg[lane2_reg], prod_reg);
        // a header, or the clear after a chunk's last row, abandons whatever is still in flight and zeroes the sums
        if (ctl.kill || clear) begin
            v1_next  = 1'b0;
            v2_next  = 1'b0;
            acc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        lane1_reg <= ctl.lane;
        val1_reg  <= data;
        lane2_reg <= lane1_reg;
        prod_reg  <= prod_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            acc_reg <= acc_next;
        end
    end

    assign busy = v1_reg || v2_reg;
    assign acc  = acc_reg;

endmodule

@@ hw/rtl/sellspmv_emit.sv @@
// Old-result memory, row result sequencer and output register.
`timescale 1ns / 1ps
module sellspmv_emit #(
    parameter int ROW_DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     old_we,
    input  logic [9:0]               index,
    input  logic [31:0]              data,
    input  sellspmv_pkg::sched_ctl_t ctl,
    input  logic                     mode,
    input  logic                     mac_busy,
    input  logic [3:0][63:0]         acc,
    output logic                     busy,
    output logic                     clear,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [9:0]               m_row,
    output logic [63:0]              m_result,
    output logic                     m_last
);
    import sellspmv_pkg::*;

    localparam int RowAw = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

    logic [63:0]        old_mem [ROW_DEPTH];
    logic signed [63:0] old_rd_reg;

    emit_state_t        state_reg, state_next;
    logic [1:0]         lane_reg, lane_next;
    logic [7:0]         chunk_reg, chunk_next;
    logic               m_valid_reg, m_valid_next;
    logic [9:0]         m_row_reg;
    logic [63:0]        m_result_reg;
    logic               m_last_reg;

    logic [9:0]         row;
    logic [RowAw-1:0]   row_addr, load_addr, wr_addr;
    logic [63:0]        wr_data;
    logic signed [63:0] result;
    logic               rd_en, out_free, load_out;

    assign row       = {chunk_reg, lane_reg};
    assign row_addr  = RowAw'(mod_const(row, ROW_DEPTH));
    assign load_addr = RowAw'(mod_const(index, ROW_DEPTH));
    assign result    = mode ? sat_add64(acc[lane_reg], old_rd_reg) : acc[lane_reg];

    always_comb begin
        state_next = state_reg;
        lane_next  = lane_reg;
        chunk_next = chunk_reg;
        unique case (state_reg)
            EM_IDLE: begin
                if (ctl.start) begin
                    state_next = EM_DRAIN;
                    lane_next  = '0;
                    chunk_next = ctl.chunk;
                end
            end
            EM_DRAIN: begin
                if (!mac_busy)
                    state_next = EM_READ;
            end
            EM_READ: begin
                state_next = EM_WRITE;
            end
            EM_WRITE: begin
                if (load_out) begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = (lane_reg == 2'd3) ? EM_IDLE : EM_READ;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    always_comb begin
        busy     = (state_reg != EM_IDLE);
        rd_en    = (state_reg == EM_READ);
        out_free = !m_valid_reg || m_ready;
        load_out = (state_reg == EM_WRITE) && out_free;
        clear    = load_out && (lane_reg == 2'd3);
    end

    // one write port: loads when idle, write-back while emitting
    always_comb begin
        if (load_out) begin
            wr_addr = row_addr;
            wr_data = result;
        end else begin
            wr_addr = load_addr;
            wr_data = {{32{data[31]}}, data};
        end
    end

    always_ff @(posedge aclk) begin
        if (old_we || load_out)
            old_mem[wr_addr] <= wr_data;
        if (rd_en)
            old_rd_reg <= old_mem[row_addr];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_row_reg    <= row;
            m_result_reg <= result;
            m_last_reg   <= (lane_reg == 2'd3);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            lane_reg    <= '0;
            chunk_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lane_reg    <= lane_next;
            chunk_reg   <= chunk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_row    = m_row_reg;
    assign m_result = m_result_reg;
    assign m_last   = m_last_reg;

endmodule

@@ hw/rtl/sliced_ell_spmv_chunk4_core.sv @@
// Top level of the sliced-ELL (four rows per chunk) sparse matrix-vector core.
`timescale 1ns / 1ps
// Loads, headers and matrix entries are taken one item per cycle while no
// chunk's results are being produced. An entry goes through a three-stage
// path: gather read of the vector memory, a 32x32 multiply, then a
// saturating add into its row accumulator. When a chunk completes (its last
// entry, or a header with all row lengths zero) input is held off while the
// path drains and the four row results are produced, each needing an
// old-result memory read and a write-back; an output-side stall holds this up.
// A result may wait in the output register while new items are taken.
// Memories come up undefined; load vector elements, and old results when
// accumulate mode is on, before they are used.
module sliced_ell_spmv_chunk4_core #(
    parameter int VECTOR_DEPTH   = 1024,
    parameter int ROW_DEPTH      = 1024,
    parameter int MAX_ROW_LENGTH = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // index[9:0], data[41:10], chunk_min[49:42], row_len_0[57:50],
    // row_len_1[65:58], row_len_2[73:66], row_len_3[81:74], zero pad
    input  logic [87:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // row_index[9:0], row_result[73:10], zero pad
    output logic [79:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import sellspmv_pkg::*;

    logic            s_accept;
    op_t             s_op;
    logic [9:0]      s_index;
    logic [31:0]     s_data;
    logic [7:0]      s_chunk_min;
    logic [3:0][7:0] s_row_len;

    logic            mode_reg, mode_next;
    sched_ctl_t      ctl;
    logic            mac_busy, emit_busy, emit_clear;
    logic [3:0][63:0] acc;
    logic [9:0]      m_row;
    logic [63:0]     m_result;

    assign s_op        = op_t'(s_tuser);
    assign s_index     = s_tdata[9:0];
    assign s_data      = s_tdata[41:10];
    assign s_chunk_min = s_tdata[49:42];
    assign s_row_len   = s_tdata[81:50];

    assign s_tready = !emit_busy;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            mode_reg <= 1'b0;
        else
            mode_reg <= mode_next;
    end

    sellspmv_sched #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
    ) u_sched (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .op        (s_op),
        .index     (s_index),
        .chunk_min (s_chunk_min),
        .row_len   (s_row_len),
        .ctl       (ctl)
    );

    sellspmv_mac #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vec_we  (s_accept && (s_op == OP_LOAD_VEC)),
        .index   (s_index),
        .data    (s_data),
        .ctl     (ctl),
        .clear   (emit_clear),
        .busy    (mac_busy),
        .acc     (acc)
    );

    sellspmv_emit #(
        .ROW_DEPTH(ROW_DEPTH)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .old_we   (s_accept && (s_op == OP_LOAD_OLD)),
        .index    (s_index),
        .data     (s_data),
        .ctl      (ctl),
        .mode     (mode_reg),
        .mac_busy (mac_busy),
        .acc      (acc),
        .busy     (emit_busy),
        .clear    (emit_clear),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_row    (m_row),
        .m_result (m_result),
        .m_last   (m_tlast)
    );

    assign m_tdata = {6'd0, m_result, m_row};

    // a completed chunk holds off input until its last row is in the output register
    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.start && aresetn) |=> !s_tready)
        else $error("input taken right after chunk completion");

    // sums are cleared only once the MAC path is empty
    a_clear_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_clear |-> !mac_busy)
        else $error("accumulators cleared with entries in flight");

    // the fourth row of a chunk carries last
    a_last_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'b11)))
        else $error("last flag does not match row lane");

endmodule
